### hw/rtl/sha256_hash_top_assert.svh
// assertion macros for the sha-256 hash block
`ifndef SHA256_HASH_TOP_ASSERT_SVH
`define SHA256_HASH_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SHA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sha256 check failed");

// next-cycle implication, sampled on clk, off during reset
`define SHA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sha256 check failed");

`endif

### hw/rtl/sha_pkg.sv
// shared types, constants and functions of the sha-256 hash block
package sha_pkg;

	localparam int unsigned SHA_WORDS  = 8;
	localparam int unsigned SHA_ROUNDS = 64;

	localparam logic [5:0] SHA_FILL_LAST = 6'd63;  // last byte slot of a block
	localparam logic [5:0] SHA_LEN_POS   = 6'd56;  // first slot of the length field
	localparam logic [5:0] SHA_RND_LAST  = 6'd63;
	localparam logic [2:0] SHA_IDX_LAST  = 3'd7;
	localparam logic [7:0] SHA_PAD_MARK  = 8'h80;

	typedef logic [SHA_WORDS-1:0][31:0] sha_words_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PAD,
		ST_ROUND,
		ST_FOLD,
		ST_OUT
	} sha_state_t;

	// controls of the block window / message schedule
	typedef struct packed {
		logic       load;    // shift one byte in
		logic [7:0] data;
		logic       step;    // one schedule step
		logic       expand;  // rounds 16..63 compute a new word
	} sha_win_ctl_t;

	// controls of the round unit
	typedef struct packed {
		logic init;    // working vars from chain
		logic step;    // one compression round
		logic fold;    // chain += working vars
		logic reinit;  // chain back to the initial values
	} sha_rnd_ctl_t;

	localparam sha_words_t SHA_IV = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

	localparam logic [31:0] SHA_K [SHA_ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	function automatic logic [31:0] sha_big0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] sha_big1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] sha_small0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] sha_small1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

### hw/rtl/sha_sched.sv
// block window: byte shift line for loading, rolling 16-word message schedule
module sha_sched import sha_pkg::*; (
	input  logic         clk,
	input  sha_win_ctl_t ctl,
	output logic [31:0]  w_t
);

	logic [0:15][31:0] win_q;  // word 0 is the oldest
	logic [31:0]       w_new;

	assign w_new = sha_small1(win_q[14]) + win_q[9] + sha_small0(win_q[1]) + win_q[0];
	assign w_t   = ctl.expand ? w_new : win_q[0];

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			win_q <= 512'({win_q, ctl.data});
		end else if (ctl.step) begin
			win_q <= {win_q[1:15], w_t};
		end
	end

endmodule

### hw/rtl/sha_round.sv
// shared round unit: working variables and chaining words
module sha_round import sha_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  sha_rnd_ctl_t ctl,
	input  logic [31:0]  k_t,
	input  logic [31:0]  w_t,
	output sha_words_t   chain
);

	sha_words_t  chain_q;
	sha_words_t  v_q;  // index 0 is a, 7 is h
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] ch;
	logic [31:0] maj;

	assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1  = v_q[7] + sha_big1(v_q[4]) + ch + k_t + w_t;
	assign t2  = sha_big0(v_q[0]) + maj;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= SHA_IV;
		end else if (ctl.reinit) begin
			chain_q <= SHA_IV;
		end else if (ctl.fold) begin
			for (int i = 0; i < SHA_WORDS; i++) begin
				chain_q[i] <= chain_q[i] + v_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			v_q <= chain_q;
		end else if (ctl.step) begin
			v_q <= {v_q[6:4], v_q[3] + t1, v_q[2:0], t1 + t2};
		end
	end

	assign chain = chain_q;

endmodule

### hw/rtl/sha256_hash_top.sv
// top level of the sha-256 hash block: sequencer, padding and digest output
//
//  channel   handshake                    payload
//  ------------------------------------------------------------------------
//  message   msg_valid / msg_stall        msg_byte, byte_valid, last_byte
//  digest    digest_valid / digest_stall  digest_word, word_index, last_word
//
// bytes are taken one per cycle while a block fills; the 64th byte of a block
// starts the compression rounds on the shared round unit and then the fold,
// during which msg_stall is high. a request with last_byte set is followed by
// padding bytes fed one per cycle up to the block end (one or two blocks, each
// with its own rounds and fold), then eight digest words, one per accepted request.
// arst_n returns the chaining words to the initial values and clears all
// counts; the block window needs no clearing since every slot is written first.
// a stalled digest word holds until taken; no new message byte is taken until
// the last digest word has gone.
module sha256_hash_top import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// message requests
	input  logic        msg_valid,
	output logic        msg_stall,
	input  logic [7:0]  msg_byte,
	input  logic        byte_valid,
	input  logic        last_byte,
	// digest requests
	output logic        digest_valid,
	input  logic        digest_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	sha_state_t   state_q, state_d;
	logic [5:0]   fill_q;    // bytes held in the current block
	logic [60:0]  total_q;   // message bytes so far, wraps
	logic [5:0]   rnd_q;     // round counter
	logic [2:0]   idx_q;     // digest word being offered
	logic         pad_q;     // message closed, padding under way
	logic         mark_q;    // 0x80 marker already placed
	logic         lenok_q;   // length field goes into this block

	sha_win_ctl_t win_ctl;
	sha_rnd_ctl_t rnd_ctl;
	sha_words_t   chain;
	logic [31:0]  w_t;
	logic [63:0]  bit_len;
	logic [7:0]   pad_byte;
	logic         msg_take;
	logic         dig_take;

	assign msg_take = msg_valid && !msg_stall;
	assign dig_take = digest_valid && !digest_stall;
	assign bit_len  = {total_q, 3'b000};

	// marker, then zeros, then the big-endian bit length in the last eight slots
	always_comb begin
		if (!mark_q) begin
			pad_byte = SHA_PAD_MARK;
		end else if (lenok_q && fill_q >= SHA_LEN_POS) begin
			pad_byte = bit_len[{~fill_q[2:0], 3'b000} +: 8];
		end else begin
			pad_byte = 8'h00;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		win_ctl        = '0;
		rnd_ctl        = '0;
		win_ctl.data   = msg_byte;
		win_ctl.expand = (rnd_q[5:4] != 2'b00);
		case (state_q)
			ST_LOAD: begin
				if (msg_valid) begin
					if (byte_valid) begin
						win_ctl.load = 1'b1;
					end
					if (byte_valid && fill_q == SHA_FILL_LAST) begin
						// block full: compress first, pad afterwards if closing
						state_d      = ST_ROUND;
						rnd_ctl.init = 1'b1;
					end else if (last_byte) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				win_ctl.load = 1'b1;
				win_ctl.data = pad_byte;
				if (fill_q == SHA_FILL_LAST) begin
					state_d      = ST_ROUND;
					rnd_ctl.init = 1'b1;
				end
			end
			ST_ROUND: begin
				win_ctl.step = 1'b1;
				rnd_ctl.step = 1'b1;
				if (rnd_q == SHA_RND_LAST) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				rnd_ctl.fold = 1'b1;
				if (!pad_q) begin
					state_d = ST_LOAD;
				end else if (mark_q && lenok_q) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_PAD;
				end
			end
			ST_OUT: begin
				if (!digest_stall && idx_q == SHA_IDX_LAST) begin
					state_d        = ST_LOAD;
					rnd_ctl.reinit = 1'b1;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// counts and padding flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			total_q <= '0;
			rnd_q   <= '0;
			idx_q   <= '0;
			pad_q   <= 1'b0;
			mark_q  <= 1'b0;
			lenok_q <= 1'b0;
		end else begin
			if (win_ctl.load) begin
				fill_q <= fill_q + 6'd1;
			end
			if (rnd_ctl.step) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (dig_take) begin
				idx_q <= idx_q + 3'd1;
			end
			if (rnd_ctl.reinit) begin
				total_q <= '0;
				pad_q   <= 1'b0;
				mark_q  <= 1'b0;
				lenok_q <= 1'b0;
			end else begin
				if (msg_take && byte_valid) begin
					total_q <= total_q + 61'd1;
				end
				if (msg_take && last_byte) begin
					pad_q <= 1'b1;
				end
				if (state_q == ST_PAD && !mark_q) begin
					mark_q  <= 1'b1;
					lenok_q <= (fill_q < SHA_LEN_POS);
				end
				// marker landed too late for the length: next block carries it
				if (rnd_ctl.fold && pad_q && mark_q && !lenok_q) begin
					lenok_q <= 1'b1;
				end
			end
		end
	end

	sha_sched u_sched (
		.clk (clk),
		.ctl (win_ctl),
		.w_t (w_t)
	);

	sha_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (rnd_ctl),
		.k_t    (SHA_K[rnd_q]),
		.w_t    (w_t),
		.chain  (chain)
	);

	assign msg_stall    = (state_q != ST_LOAD);
	assign digest_valid = (state_q == ST_OUT);
	assign digest_word  = chain[idx_q];
	assign word_index   = idx_q;
	assign last_word    = (idx_q == SHA_IDX_LAST);

	`include "sha256_hash_top_assert.svh"

	// no message byte is taken while a digest is offered
	`SHA_ASSERT_NOW(a_out_blocks_in, digest_valid, msg_stall)
	// a closing request always leaves the load state
	`SHA_ASSERT_NEXT(a_last_leaves_load, msg_take && last_byte, msg_stall)
	// the final round is always followed by the fold
	`SHA_ASSERT_NEXT(a_round_to_fold, state_q == ST_ROUND && rnd_q == SHA_RND_LAST,
		state_q == ST_FOLD)
	// after the last digest word the block is empty and ready for a new message
	`SHA_ASSERT_NEXT(a_done_clean, dig_take && last_word,
		!msg_stall && fill_q == 6'd0 && total_q == 61'd0 && idx_q == 3'd0)

endmodule
